// ===== rtl/phase_gray_code_pixel_decoder_unit_defines.svh =====
// Assertion macros for the phase and Gray-code pixel decoder
`ifndef PHASE_GRAY_CODE_PIXEL_DECODER_UNIT_DEFINES_SVH
`define PHASE_GRAY_CODE_PIXEL_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PGCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pgcd: implication check failed");

// next-cycle implication, disabled while in reset
`define PGCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pgcd: next-cycle check failed");

`endif

// ===== rtl/pgcd_pkg.sv =====
// Shared types and constants of the phase and Gray-code pixel decoder
`timescale 1ns / 1ps
`default_nettype none
package pgcd_pkg;

	localparam int PHASE_STEPS  = 4;
	localparam int SAMPLE_W     = 8;
	localparam int SUM_W        = 10;
	localparam int CORDIC_ITERS = 24;
	localparam int XY_W         = 32;
	localparam int Z_W          = 34;
	localparam int PRE_SHIFT    = 20;
	localparam int UNWRAP_W     = 22;
	localparam int WRAP_W       = 16;
	localparam int ORDER_OUT_W  = 6;
	localparam int PCOUNT_W     = 7;
	localparam int CFG_DATA_W   = 10;
	localparam int CFG_IDX_W    = 2;
	localparam int M_DATA_W     = 56;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHADOW_EN    = 2'd2;

	localparam logic [PCOUNT_W-1:0] PCOUNT_RESET   = 7'd32;
	localparam logic [SUM_W-1:0]    THRESH_RESET   = 10'd20;
	localparam logic                SHADOW_RESET   = 1'b1;
	localparam logic [PCOUNT_W-1:0] PCOUNT_MAX     = 7'd64;

	localparam logic signed [Z_W-1:0] Z_HALF_TURN = 34'sd2147483648;

	localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
		34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
		34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
		34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
		34'sd652,       34'sd326,       34'sd163,       34'sd81
	};

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   zero;
	} vec_t;

	typedef struct packed {
		logic [PCOUNT_W-1:0] period_count;
		logic [SUM_W-1:0]    threshold;
		logic                shadow_en;
	} cfg_t;

endpackage
`default_nettype wire

// ===== rtl/pgcd_front.sv =====
// Entry stage: sample sum, Gray thresholding and CORDIC pre-rotation
`timescale 1ns / 1ps
`default_nettype none
module pgcd_front #(
	parameter int GRAY_IMAGES = 6
) (
	input  wire logic                                               clk,
	input  wire logic                                               arst_n,
	input  wire logic                                               up_valid,
	output logic                                                    up_ready,
	input  wire logic [pgcd_pkg::PHASE_STEPS-1:0][pgcd_pkg::SAMPLE_W-1:0] phase,
	input  wire logic [GRAY_IMAGES-1:0][pgcd_pkg::SAMPLE_W-1:0]     gray,
	output logic                                                    dn_valid,
	input  wire logic                                               dn_ready,
	output pgcd_pkg::vec_t                                          dn_vec,
	output logic [GRAY_IMAGES+pgcd_pkg::SUM_W-1:0]                  dn_side
);
	import pgcd_pkg::*;

	logic [SUM_W-1:0] sum;
	logic [GRAY_IMAGES-1:0] bits;
	logic signed [SAMPLE_W:0] dx, dy;
	logic signed [XY_W-1:0] dx_w, dy_w;
	vec_t vec_d;

	logic valid_s1;
	vec_t vec_s1;
	logic [GRAY_IMAGES+SUM_W-1:0] side_s1;

	always_comb begin
		sum = {2'b00, phase[0]} + {2'b00, phase[1]} + {2'b00, phase[2]} + {2'b00, phase[3]};
		for (int k = 0; k < GRAY_IMAGES; k++) begin
			bits[k] = ({gray[k], 2'b00} > sum);
		end
		dx = $signed({1'b0, phase[0]}) - $signed({1'b0, phase[2]});
		dy = $signed({1'b0, phase[1]}) - $signed({1'b0, phase[3]});
		dx_w = {{(XY_W-SAMPLE_W-1){dx[SAMPLE_W]}}, dx};
		dy_w = {{(XY_W-SAMPLE_W-1){dy[SAMPLE_W]}}, dy};
		vec_d.zero = (dx == '0) && (dy == '0);
		if (dx[SAMPLE_W]) begin
			vec_d.z = dy[SAMPLE_W] ? -Z_HALF_TURN : Z_HALF_TURN;
			vec_d.x = (-dx_w) <<< PRE_SHIFT;
			vec_d.y = (-dy_w) <<< PRE_SHIFT;
		end else begin
			vec_d.z = '0;
			vec_d.x = dx_w <<< PRE_SHIFT;
			vec_d.y = dy_w <<< PRE_SHIFT;
		end
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_valid && up_ready) begin
			valid_s1 <= 1'b1;
		end else if (dn_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			vec_s1  <= vec_d;
			side_s1 <= {bits, sum};
		end
	end

	assign dn_valid = valid_s1;
	assign dn_vec   = vec_s1;
	assign dn_side  = side_s1;

endmodule
`default_nettype wire

// ===== rtl/pgcd_cordic_cell.sv =====
// One vectoring CORDIC iteration with its own register and beat handshake
`timescale 1ns / 1ps
`default_nettype none
module pgcd_cordic_cell #(
	parameter int STAGE  = 0,
	parameter int SIDE_W = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              up_valid,
	output logic                   up_ready,
	input  wire pgcd_pkg::vec_t    up_vec,
	input  wire logic [SIDE_W-1:0] up_side,
	output logic                   dn_valid,
	input  wire logic              dn_ready,
	output pgcd_pkg::vec_t         dn_vec,
	output logic [SIDE_W-1:0]      dn_side
);
	import pgcd_pkg::*;

	logic signed [XY_W-1:0] sx, sy;
	vec_t vec_d;
	logic valid_q;
	vec_t vec_q;
	logic [SIDE_W-1:0] side_q;

	always_comb begin
		sx = up_vec.y >>> STAGE;
		sy = up_vec.x >>> STAGE;
		vec_d.zero = up_vec.zero;
		if (up_vec.y > 0) begin
			vec_d.x = up_vec.x + sx;
			vec_d.y = up_vec.y - sy;
			vec_d.z = up_vec.z + ATAN_TAB[STAGE];
		end else begin
			vec_d.x = up_vec.x - sx;
			vec_d.y = up_vec.y + sy;
			vec_d.z = up_vec.z - ATAN_TAB[STAGE];
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_valid && up_ready) begin
			valid_q <= 1'b1;
		end else if (dn_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			vec_q  <= vec_d;
			side_q <= up_side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_vec   = vec_q;
	assign dn_side  = side_q;

endmodule
`default_nettype wire

// ===== rtl/pgcd_resolve.sv =====
// Phase rounding, Gray decode, fringe order selection and output register
`timescale 1ns / 1ps
`default_nettype none
module pgcd_resolve #(
	parameter int GRAY_IMAGES     = 6,
	parameter int PHASE_FRAC_BITS = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire pgcd_pkg::cfg_t                          cfg,
	input  wire logic                                    up_valid,
	output logic                                         up_ready,
	input  wire pgcd_pkg::vec_t                          up_vec,
	input  wire logic [GRAY_IMAGES+pgcd_pkg::SUM_W-1:0]  up_side,
	output logic                                         dn_valid,
	input  wire logic                                    dn_ready,
	output logic [pgcd_pkg::UNWRAP_W-1:0]                unwrapped_phase,
	output logic                                         pixel_valid,
	output logic signed [pgcd_pkg::WRAP_W-1:0]           wrapped_phase,
	output logic [pgcd_pkg::ORDER_OUT_W-1:0]             fringe_order,
	output logic [pgcd_pkg::SUM_W-1:0]                   confidence_sum
);
	import pgcd_pkg::*;

	localparam int F  = PHASE_FRAC_BITS;
	localparam int G  = GRAY_IMAGES;
	localparam int OW = (G > 6) ? 7 : 6;
	localparam int QUARTER = 1 << (F - 2);
	localparam logic signed [Z_W-1:0] ROUND_C = Z_W'(64'sd1 <<< (31 - F));
	localparam logic [OW-1:0] ORDER_UNDER = OW'(63);

	// stage A
	logic signed [Z_W-1:0] rsum;
	logic [G-1:0] bits;
	logic [G-1:0] t;
	logic [G-2:0] k1_d;
	logic valid_s26;
	logic [F-1:0] rf_s26;
	logic [G-2:0] k1_s26;
	logic [G-1:0] k2_s26;
	logic [SUM_W-1:0] sum_s26;
	logic rdy_a, rdy_b;

	// stage B
	logic signed [F-1:0] w;
	logic lo, hi, under, lit, ok;
	logic [OW-1:0] order;
	logic [PCOUNT_W-1:0] limit;
	logic [OW+F-1:0] uw;
	logic [OW+F+UNWRAP_W-1:0] uw_ext;
	logic [F+WRAP_W-1:0] w_ext;
	logic valid_s27;
	logic [UNWRAP_W-1:0] unwrap_s27;
	logic ok_s27;
	logic [WRAP_W-1:0] wrap_s27;
	logic [ORDER_OUT_W-1:0] order_s27;
	logic [SUM_W-1:0] sum_s27;

	always_comb begin
		rsum = ROUND_C - up_vec.z;
		bits = up_side[SUM_W +: G];
		t[0] = bits[0];
		for (int k = 1; k < G; k++) begin
			t[k] = t[k-1] ^ bits[k];
		end
		for (int k = 0; k < G - 1; k++) begin
			k1_d[G-2-k] = t[k];
		end
	end

	assign rdy_b    = !valid_s27 || dn_ready;
	assign rdy_a    = !valid_s26 || rdy_b;
	assign up_ready = rdy_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s26 <= 1'b0;
		end else if (up_valid && rdy_a) begin
			valid_s26 <= 1'b1;
		end else if (rdy_b) begin
			valid_s26 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && rdy_a) begin
			rf_s26  <= up_vec.zero ? '0 : rsum[31 -: F];
			k1_s26  <= k1_d;
			k2_s26  <= G'(k1_d) + G'(t[G-1]);
			sum_s26 <= up_side[SUM_W-1:0];
		end
	end

	always_comb begin
		w     = $signed(rf_s26);
		lo    = (w <= -QUARTER);
		hi    = (w >= QUARTER);
		under = 1'b0;
		if (lo) begin
			order = OW'(k2_s26);
		end else if (hi) begin
			if (k2_s26 == '0) begin
				under = 1'b1;
				order = ORDER_UNDER;
			end else begin
				order = OW'(k2_s26 - 1'b1);
			end
		end else begin
			order = OW'(k1_s26);
		end
		limit  = (cfg.period_count > PCOUNT_MAX) ? PCOUNT_MAX : cfg.period_count;
		lit    = !(cfg.shadow_en && (sum_s26 <= cfg.threshold));
		ok     = !under && ({1'b0, order} < {1'b0, limit}) && lit;
		uw     = {order, ~rf_s26[F-1], rf_s26[F-2:0]};
		uw_ext = {{UNWRAP_W{1'b0}}, uw};
		w_ext  = {{WRAP_W{rf_s26[F-1]}}, rf_s26};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s27 <= 1'b0;
		end else if (valid_s26 && rdy_b) begin
			valid_s27 <= 1'b1;
		end else if (dn_ready) begin
			valid_s27 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s26 && rdy_b) begin
			unwrap_s27 <= ok ? uw_ext[UNWRAP_W-1:0] : '0;
			ok_s27     <= ok;
			wrap_s27   <= w_ext[WRAP_W-1:0];
			order_s27  <= order[ORDER_OUT_W-1:0];
			sum_s27    <= sum_s26;
		end
	end

	assign dn_valid        = valid_s27;
	assign unwrapped_phase = unwrap_s27;
	assign pixel_valid     = ok_s27;
	assign wrapped_phase   = wrap_s27;
	assign fringe_order    = order_s27;
	assign confidence_sum  = sum_s27;

endmodule
`default_nettype wire

// ===== rtl/phase_gray_code_pixel_decoder_unit.sv =====
// Top level of the phase-shift and complementary Gray-code pixel decoder
`timescale 1ns / 1ps
`default_nettype none
// Decodes one pixel per beat and sustains one pixel per clock while m_tready
// stays high. Each pixel goes through an entry stage, a chain of 24 CORDIC
// cells (one vectoring iteration per cell, each with its own register) and
// two resolve stages, each registered in turn. Every stage holds its own
// valid bit and ready runs back along the chain, so input beats keep flowing
// into empty stages while a finished result waits on m_tready; s_tready drops
// only once every stage is full. Configuration writes are meant for idle
// periods; the new values apply to pixels reaching the resolve stage.
`include "phase_gray_code_pixel_decoder_unit_defines.svh"
module phase_gray_code_pixel_decoder_unit #(
	parameter int GRAY_IMAGES     = 6,
	parameter int PHASE_FRAC_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [pgcd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [pgcd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// phase_sample_0..3, gray_sample_0..GRAY_IMAGES-1, 8 bits each
	input  wire logic [32+8*GRAY_IMAGES-1:0]           s_tdata,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// unwrapped_phase[21:0], wrapped_phase[37:22], fringe_order[43:38],
	// confidence_sum[53:44], zero pad[55:54]
	output logic [pgcd_pkg::M_DATA_W-1:0]              m_tdata,
	// pixel_valid[0]
	output logic [0:0]                                 m_tuser
);
	import pgcd_pkg::*;

	localparam int SIDE_W = GRAY_IMAGES + SUM_W;

	cfg_t cfg_q;

	logic [PHASE_STEPS-1:0][SAMPLE_W-1:0] phase;
	logic [GRAY_IMAGES-1:0][SAMPLE_W-1:0] gray;

	logic              valid_c [CORDIC_ITERS+1];
	logic              ready_c [CORDIC_ITERS+1];
	vec_t              vec_c   [CORDIC_ITERS+1];
	logic [SIDE_W-1:0] side_c  [CORDIC_ITERS+1];

	logic [UNWRAP_W-1:0]      unwrapped_phase;
	logic                     pixel_valid;
	logic signed [WRAP_W-1:0] wrapped_phase;
	logic [ORDER_OUT_W-1:0]   fringe_order;
	logic [SUM_W-1:0]         confidence_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_count <= PCOUNT_RESET;
			cfg_q.threshold    <= THRESH_RESET;
			cfg_q.shadow_en    <= SHADOW_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PERIOD_COUNT: cfg_q.period_count <= cfg_wdata[PCOUNT_W-1:0];
				REG_THRESHOLD:    cfg_q.threshold    <= cfg_wdata[SUM_W-1:0];
				REG_SHADOW_EN:    cfg_q.shadow_en    <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign phase = s_tdata[31:0];
	assign gray  = s_tdata[32 +: 8*GRAY_IMAGES];

	pgcd_front #(
		.GRAY_IMAGES(GRAY_IMAGES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (s_tvalid),
		.up_ready (s_tready),
		.phase    (phase),
		.gray     (gray),
		.dn_valid (valid_c[0]),
		.dn_ready (ready_c[0]),
		.dn_vec   (vec_c[0]),
		.dn_side  (side_c[0])
	);

	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cell
		pgcd_cordic_cell #(
			.STAGE  (i),
			.SIDE_W (SIDE_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (valid_c[i]),
			.up_ready (ready_c[i]),
			.up_vec   (vec_c[i]),
			.up_side  (side_c[i]),
			.dn_valid (valid_c[i+1]),
			.dn_ready (ready_c[i+1]),
			.dn_vec   (vec_c[i+1]),
			.dn_side  (side_c[i+1])
		);
	end

	pgcd_resolve #(
		.GRAY_IMAGES     (GRAY_IMAGES),
		.PHASE_FRAC_BITS (PHASE_FRAC_BITS)
	) u_resolve (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.up_valid        (valid_c[CORDIC_ITERS]),
		.up_ready        (ready_c[CORDIC_ITERS]),
		.up_vec          (vec_c[CORDIC_ITERS]),
		.up_side         (side_c[CORDIC_ITERS]),
		.dn_valid        (m_tvalid),
		.dn_ready        (m_tready),
		.unwrapped_phase (unwrapped_phase),
		.pixel_valid     (pixel_valid),
		.wrapped_phase   (wrapped_phase),
		.fringe_order    (fringe_order),
		.confidence_sum  (confidence_sum)
	);

	assign m_tdata = {2'b00, confidence_sum, fringe_order, wrapped_phase, unwrapped_phase};
	assign m_tuser = pixel_valid;

	`PGCD_ASSERT_IMPLY(a_invalid_zero, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata[21:0] == '0)
	`PGCD_ASSERT_IMPLY(a_lit_when_valid, clk, arst_n, m_tvalid && m_tuser[0] && cfg_q.shadow_en, m_tdata[53:44] > cfg_q.threshold)
	`PGCD_ASSERT_IMPLY(a_stall_from_output, clk, arst_n, !s_tready, m_tvalid && !m_tready)

endmodule
`default_nettype wire
